// File: sv/ecc_pkg.sv
// ecc_pkg: shared types, constants and helpers for the elevator car controller
// used by every module of the block; depends on nothing else

package ecc_pkg;

   // sizing
   localparam int QUEUE_DEPTH = 16;
   localparam int FLOOR_COUNT = 8;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QUEUE_AW + 1;
   localparam int FLOOR_W     = 3;
   localparam int HEIGHT_W    = 15;
   localparam int LAMP_W      = 8;
   localparam int PITCH_W     = 12;
   localparam int STEP_W      = 12;
   localparam int TICKS_W     = 16;
   localparam int DOOR_W      = 10;
   localparam int CMD_W       = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // configuration reset values
   localparam logic [PITCH_W-1:0] PITCH_RESET       = PITCH_W'(256);
   localparam logic [STEP_W-1:0]  TRAVEL_STEP_RESET = STEP_W'(4);
   localparam logic [TICKS_W-1:0] OPEN_TICKS_RESET  = TICKS_W'(300);
   localparam logic [DOOR_W-1:0]  DOOR_STEP_RESET   = DOOR_W'(2);
   localparam logic [DOOR_W-1:0]  DOOR_TRAVEL_RESET = DOOR_W'(64);

   // ground floor index after reset
   localparam logic [FLOOR_W-1:0] GROUND_FLOOR = FLOOR_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK    = 3'd0,
      CMD_REQUEST = 3'd1,
      CMD_OPEN    = 3'd2,
      CMD_CLOSE   = 3'd3,
      CMD_STOP    = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_MOVING  = 2'd1,
      MODE_OPEN    = 2'd2,
      MODE_STOPPED = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FLOOR_PITCH = 3'd0,
      CSR_TRAVEL_STEP = 3'd1,
      CSR_OPEN_TICKS  = 3'd2,
      CSR_DOOR_STEP   = 3'd3,
      CSR_DOOR_TRAVEL = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PITCH_W-1:0] floor_pitch;
      logic [STEP_W-1:0]  travel_step;
      logic [TICKS_W-1:0] door_open_ticks;
      logic [DOOR_W-1:0]  door_step;
      logic [DOOR_W-1:0]  door_travel;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [FLOOR_W-1:0] floor;
      logic               light_lamp;
   } item_type;

   typedef struct packed {
      mode_type            mode;
      logic [HEIGHT_W-1:0] height;
      logic [FLOOR_W-1:0]  reached;
      logic [FLOOR_W-1:0]  goal;
      logic                doors_open;
      logic                opening;
      logic                closing;
      logic                extended;
      logic [TICKS_W-1:0]  elapsed;
      logic [DOOR_W-1:0]   door_pos;
      logic [LAMP_W-1:0]   lamps;
   } car_state_type;

   typedef struct packed {
      logic               push;
      logic               pop;
      logic [FLOOR_W-1:0] push_floor;
   } queue_ctrl_type;

   typedef struct packed {
      logic [QCNT_W-1:0]  fill;
      logic [FLOOR_W-1:0] head_floor;
   } queue_stat_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] car_position;
      logic [FLOOR_W-1:0]  current_floor;
      logic [FLOOR_W-1:0]  target_floor;
      mode_type            mode;
      logic                doors_open_flag;
      logic [DOOR_W-1:0]   door_offset;
      logic [LAMP_W-1:0]   lamp_bits;
      logic                request_dropped;
      logic [QCNT_W-1:0]   queue_count;
   } rsp_type;

   // requested floors above the top floor go to the top floor
   function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [FLOOR_W-1:0] fl);
      logic [FLOOR_W:0] top_floor;
      top_floor = (FLOOR_W+1)'(FLOOR_COUNT - 1);
      if ({1'b0, fl} > top_floor) begin
         return top_floor[FLOOR_W-1:0];
      end
      return fl;
   endfunction

endpackage

// File: sv/ecc_queue.sv
// ecc_queue: request queue storage with head pointer and fill count
// depends on ecc_pkg

module ecc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  ecc_pkg::queue_ctrl_type ctrl,
   output ecc_pkg::queue_stat_type stat
);

   logic [ecc_pkg::FLOOR_W-1:0]  slot_ff [ecc_pkg::QUEUE_DEPTH];
   logic [ecc_pkg::QUEUE_AW-1:0] head_ff, head_in;
   logic [ecc_pkg::QCNT_W-1:0]   fill_ff, fill_in;
   logic [ecc_pkg::QCNT_W-1:0]   slot_sum;
   logic [ecc_pkg::QUEUE_AW-1:0] wr_addr;

   // tail slot, wrapped past the end of the storage
   always_comb begin
      slot_sum = ecc_pkg::QCNT_W'(head_ff) + fill_ff;
      if (slot_sum >= ecc_pkg::QCNT_W'(ecc_pkg::QUEUE_DEPTH)) begin
         slot_sum = slot_sum - ecc_pkg::QCNT_W'(ecc_pkg::QUEUE_DEPTH);
      end
      wr_addr = slot_sum[ecc_pkg::QUEUE_AW-1:0];
   end

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (ctrl.pop) begin
         if (head_ff == ecc_pkg::QUEUE_AW'(ecc_pkg::QUEUE_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + 1'b1;
         end
      end
      if (ctrl.push && !ctrl.pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         slot_ff[wr_addr] <= ctrl.push_floor;
      end
   end

   assign stat.fill       = fill_ff;
   assign stat.head_floor = slot_ff[head_ff];

endmodule

// File: sv/ecc_car.sv
// ecc_car: car, door and lamp state with the per-transaction update logic
// depends on ecc_pkg; drives the request queue through ecc_pkg::queue_ctrl_type

module ecc_car (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  ecc_pkg::item_type       item,
   input  ecc_pkg::cfg_type        cfg,
   input  ecc_pkg::queue_stat_type qstat,
   output ecc_pkg::queue_ctrl_type qctrl,
   output ecc_pkg::rsp_type        result
);

   ecc_pkg::car_state_type car_ff, car_in;

   logic                          push, pop, dropped;
   logic [ecc_pkg::FLOOR_W-1:0]   req_floor;
   logic [ecc_pkg::HEIGHT_W-1:0]  goal_h;
   logic [ecc_pkg::HEIGHT_W:0]    sum_up;
   logic [ecc_pkg::HEIGHT_W+1:0]  diff_dn;
   logic [ecc_pkg::HEIGHT_W-1:0]  moved_h;
   logic                          arrived;
   logic [ecc_pkg::DOOR_W:0]      door_sum;
   logic [ecc_pkg::QCNT_W-1:0]    fill_after;

   assign req_floor = ecc_pkg::clamp_floor(item.floor);

   always_comb begin
      car_in  = car_ff;
      push    = 1'b0;
      pop     = 1'b0;
      dropped = 1'b0;
      goal_h  = '0;
      sum_up  = '0;
      diff_dn = '0;
      moved_h = '0;
      arrived = 1'b0;
      door_sum = '0;
      case (ecc_pkg::cmd_type'(item.command))
         ecc_pkg::CMD_TICK: begin
            if (car_in.elapsed != '1) begin
               car_in.elapsed = car_in.elapsed + 1'b1;
            end
            // open period over
            if (car_in.mode == ecc_pkg::MODE_OPEN &&
                car_in.elapsed >= cfg.door_open_ticks) begin
               car_in.doors_open = 1'b0;
               car_in.mode       = ecc_pkg::MODE_IDLE;
               car_in.opening    = 1'b0;
               car_in.closing    = 1'b1;
            end
            // take the next request
            if (car_in.mode == ecc_pkg::MODE_IDLE && qstat.fill != '0) begin
               car_in.goal = qstat.head_floor;
               pop         = 1'b1;
               car_in.mode = ecc_pkg::MODE_MOVING;
            end
            // one travel step
            if (car_in.mode == ecc_pkg::MODE_MOVING) begin
               goal_h = ecc_pkg::HEIGHT_W'(car_in.goal) *
                        ecc_pkg::HEIGHT_W'(cfg.floor_pitch);
               if (goal_h > car_in.height) begin
                  sum_up  = {1'b0, car_in.height} +
                            (ecc_pkg::HEIGHT_W+1)'(cfg.travel_step);
                  arrived = sum_up >= {1'b0, goal_h};
                  moved_h = sum_up[ecc_pkg::HEIGHT_W-1:0];
               end else begin
                  diff_dn = {2'b00, car_in.height} -
                            (ecc_pkg::HEIGHT_W+2)'(cfg.travel_step);
                  arrived = diff_dn[ecc_pkg::HEIGHT_W+1] ||
                            (diff_dn <= {2'b00, goal_h});
                  moved_h = diff_dn[ecc_pkg::HEIGHT_W-1:0];
               end
               if (arrived) begin
                  car_in.height     = goal_h;
                  car_in.reached    = car_in.goal;
                  car_in.doors_open = 1'b1;
                  car_in.mode       = ecc_pkg::MODE_OPEN;
                  car_in.elapsed    = '0;
                  car_in.opening    = 1'b1;
                  car_in.closing    = 1'b0;
                  car_in.extended   = 1'b0;
                  car_in.lamps      = car_in.lamps &
                                      ~(ecc_pkg::LAMP_W'(1) << car_in.goal);
               end else begin
                  car_in.height = moved_h;
               end
            end
            // door animation
            if (car_in.opening) begin
               door_sum = {1'b0, car_in.door_pos} + {1'b0, cfg.door_step};
               if (door_sum >= {1'b0, cfg.door_travel}) begin
                  car_in.door_pos = cfg.door_travel;
                  car_in.opening  = 1'b0;
               end else begin
                  car_in.door_pos = door_sum[ecc_pkg::DOOR_W-1:0];
               end
            end
            if (car_in.closing) begin
               if (car_in.door_pos <= cfg.door_step) begin
                  car_in.door_pos = '0;
                  car_in.closing  = 1'b0;
                  car_in.extended = 1'b0;
               end else begin
                  car_in.door_pos = car_in.door_pos - cfg.door_step;
               end
            end
         end
         ecc_pkg::CMD_REQUEST: begin
            if (qstat.fill >= ecc_pkg::QCNT_W'(ecc_pkg::QUEUE_DEPTH)) begin
               dropped = 1'b1;
            end else begin
               push = 1'b1;
               if (item.light_lamp) begin
                  car_in.lamps = car_in.lamps | (ecc_pkg::LAMP_W'(1) << req_floor);
               end
            end
         end
         ecc_pkg::CMD_OPEN: begin
            if (!car_in.doors_open && car_in.mode == ecc_pkg::MODE_IDLE) begin
               car_in.doors_open = 1'b1;
               car_in.mode       = ecc_pkg::MODE_OPEN;
               car_in.elapsed    = '0;
               car_in.opening    = 1'b1;
               car_in.closing    = 1'b0;
               car_in.extended   = 1'b0;
            end else if (car_in.doors_open && !car_in.extended) begin
               car_in.elapsed  = '0;
               car_in.extended = 1'b1;
            end
         end
         ecc_pkg::CMD_CLOSE: begin
            if (car_in.doors_open) begin
               car_in.closing    = 1'b1;
               car_in.opening    = 1'b0;
               car_in.doors_open = 1'b0;
               car_in.elapsed    = cfg.door_open_ticks;
               car_in.extended   = 1'b0;
            end
         end
         ecc_pkg::CMD_STOP: begin
            car_in.mode = ecc_pkg::MODE_STOPPED;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         car_ff.mode       <= ecc_pkg::MODE_IDLE;
         car_ff.height     <= '0;
         car_ff.reached    <= ecc_pkg::GROUND_FLOOR;
         car_ff.goal       <= ecc_pkg::GROUND_FLOOR;
         car_ff.doors_open <= 1'b0;
         car_ff.opening    <= 1'b0;
         car_ff.closing    <= 1'b0;
         car_ff.extended   <= 1'b0;
         car_ff.elapsed    <= '0;
         car_ff.door_pos   <= '0;
         car_ff.lamps      <= '0;
      end else if (fire) begin
         car_ff <= car_in;
      end
   end

   assign qctrl.push       = fire && push;
   assign qctrl.pop        = fire && pop;
   assign qctrl.push_floor = req_floor;

   always_comb begin
      fill_after = qstat.fill;
      if (push) begin
         fill_after = qstat.fill + 1'b1;
      end else if (pop) begin
         fill_after = qstat.fill - 1'b1;
      end
   end

   assign result.car_position    = car_in.height;
   assign result.current_floor   = car_in.reached;
   assign result.target_floor    = car_in.goal;
   assign result.mode            = car_in.mode;
   assign result.doors_open_flag = car_in.doors_open;
   assign result.door_offset     = car_in.door_pos;
   assign result.lamp_bits       = car_in.lamps;
   assign result.request_dropped = dropped;
   assign result.queue_count     = fill_after;

endmodule

// File: sv/elevator_car_controller_top.sv
// elevator_car_controller_top: top level of the single-car elevator controller
// depends on ecc_pkg, ecc_queue and ecc_car
//
// usage
//  - req channel: one transaction per command (tick, floor request, open,
//    close, stop) with req_floor and req_light_lamp as its operands
//  - rsp channel: exactly one transaction per req transaction, in order,
//    showing the car state after that command plus the dropped flag
//  - csr port: plain write port, index 0 floor pitch, 1 travel step,
//    2 door open ticks, 3 door step, 4 door travel; other indexes ignored;
//    write only while no transaction is in flight
//  - path: a req transaction goes into the input register, then the state
//    update lands in the result register, where rsp_valid rises
//  - throughput: one transaction per cycle while rsp_stall stays low, as the
//    state update between the input register and the result register is combinational
//  - receiver stall: the result register holds its transaction; the input
//    register still takes one more transaction, then req_stall rises
//  - reset: synchronous, car idle at the ground floor with doors shut,
//    queue empty, lamps dark, configuration back to its defaults

module elevator_car_controller_top (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ecc_pkg::CMD_W-1:0]        req_command,
   input  logic [ecc_pkg::FLOOR_W-1:0]      req_floor,
   input  logic                             req_light_lamp,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ecc_pkg::HEIGHT_W-1:0]     rsp_car_position,
   output logic [ecc_pkg::FLOOR_W-1:0]      rsp_current_floor,
   output logic [ecc_pkg::FLOOR_W-1:0]      rsp_target_floor,
   output logic [1:0]                       rsp_mode,
   output logic                             rsp_doors_open_flag,
   output logic [ecc_pkg::DOOR_W-1:0]       rsp_door_offset,
   output logic [ecc_pkg::LAMP_W-1:0]       rsp_lamp_bits,
   output logic                             rsp_request_dropped,
   output logic [ecc_pkg::QCNT_W-1:0]       rsp_queue_count,
   // configuration
   input  logic                             csr_write_en,
   input  logic [ecc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ecc_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   ecc_pkg::cfg_type        cfg_ff;
   ecc_pkg::item_type       item_ff;
   logic                    item_valid_ff;
   ecc_pkg::rsp_type        rsp_ff;
   ecc_pkg::rsp_type        rsp_in;
   logic                    rsp_valid_ff;
   logic                    advance;
   logic                    fire;
   logic                    take_req;
   ecc_pkg::queue_ctrl_type qctrl;
   ecc_pkg::queue_stat_type qstat;

   // result register free or being emptied this cycle
   assign advance  = !rsp_valid_ff || !rsp_stall;
   // the buffered transaction is processed and moved on
   assign fire     = item_valid_ff && advance;
   assign req_stall = item_valid_ff && !advance;
   assign take_req = req_valid && !req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.floor_pitch     <= ecc_pkg::PITCH_RESET;
         cfg_ff.travel_step     <= ecc_pkg::TRAVEL_STEP_RESET;
         cfg_ff.door_open_ticks <= ecc_pkg::OPEN_TICKS_RESET;
         cfg_ff.door_step       <= ecc_pkg::DOOR_STEP_RESET;
         cfg_ff.door_travel     <= ecc_pkg::DOOR_TRAVEL_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            ecc_pkg::CSR_FLOOR_PITCH:
               cfg_ff.floor_pitch <= csr_write_data[ecc_pkg::PITCH_W-1:0];
            ecc_pkg::CSR_TRAVEL_STEP:
               cfg_ff.travel_step <= csr_write_data[ecc_pkg::STEP_W-1:0];
            ecc_pkg::CSR_OPEN_TICKS:
               cfg_ff.door_open_ticks <= csr_write_data[ecc_pkg::TICKS_W-1:0];
            ecc_pkg::CSR_DOOR_STEP:
               cfg_ff.door_step <= csr_write_data[ecc_pkg::DOOR_W-1:0];
            ecc_pkg::CSR_DOOR_TRAVEL:
               cfg_ff.door_travel <= csr_write_data[ecc_pkg::DOOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (take_req) begin
         item_valid_ff <= 1'b1;
      end else if (fire) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         item_ff.command    <= req_command;
         item_ff.floor      <= req_floor;
         item_ff.light_lamp <= req_light_lamp;
      end
   end

   ecc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctrl  (qctrl),
      .stat  (qstat)
   );

   ecc_car u_car (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .qstat  (qstat),
      .qctrl  (qctrl),
      .result (rsp_in)
   );

   // result register, holds while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_car_position    = rsp_ff.car_position;
   assign rsp_current_floor   = rsp_ff.current_floor;
   assign rsp_target_floor    = rsp_ff.target_floor;
   assign rsp_mode            = rsp_ff.mode;
   assign rsp_doors_open_flag = rsp_ff.doors_open_flag;
   assign rsp_door_offset     = rsp_ff.door_offset;
   assign rsp_lamp_bits       = rsp_ff.lamp_bits;
   assign rsp_request_dropped = rsp_ff.request_dropped;
   assign rsp_queue_count     = rsp_ff.queue_count;

endmodule

// File: sv/ecc_checker.sv
// ecc_checker: port-level checks on the elevator car controller
// depends on ecc_pkg; bound to elevator_car_controller_top below

module ecc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [1:0]                     rsp_mode,
   input logic                           rsp_doors_open_flag,
   input logic                           rsp_request_dropped,
   input logic [ecc_pkg::QCNT_W-1:0]     rsp_queue_count,
   input logic [ecc_pkg::HEIGHT_W-1:0]   rsp_car_position
);

   // a stalled result transaction stays and keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_car_position) &&
                                 $stable(rsp_queue_count))
      else $error("stalled rsp transaction changed");

   // input backs up only behind a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled with the result side free");

   // a dropped request only happens on a full queue
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_request_dropped |->
         rsp_queue_count == ecc_pkg::QCNT_W'(ecc_pkg::QUEUE_DEPTH))
      else $error("request dropped with room in the queue");

   // queue never overfills
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_queue_count <= ecc_pkg::QCNT_W'(ecc_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // open doors only in the open or stopped mode
   a_doors_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_doors_open_flag |->
         rsp_mode == ecc_pkg::MODE_OPEN || rsp_mode == ecc_pkg::MODE_STOPPED)
      else $error("doors open while idle or moving");

endmodule

bind elevator_car_controller_top ecc_checker u_ecc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_mode            (rsp_mode),
   .rsp_doors_open_flag (rsp_doors_open_flag),
   .rsp_request_dropped (rsp_request_dropped),
   .rsp_queue_count     (rsp_queue_count),
   .rsp_car_position    (rsp_car_position)
);

// File: tb/ecc_car_tracker_pkg.sv
// ecc_car_tracker_pkg: expected-behaviour tracker of the elevator car controller,
// kept as a small class that follows every transaction and checks every result
// depends on ecc_pkg for widths, codes and the result struct
`timescale 1ns / 1ps

package ecc_car_tracker_pkg;
   import ecc_pkg::*;

   // command codes the block ignores
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_W'(CMD_STOP) + CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = {CMD_W{1'b1}};

   class car_tracker;
      logic [PITCH_W-1:0]  pitch;
      logic [STEP_W-1:0]   travel;
      logic [TICKS_W-1:0]  open_limit;
      logic [DOOR_W-1:0]   door_rate;
      logic [DOOR_W-1:0]   door_full;

      mode_type            mode;
      logic [HEIGHT_W-1:0] height;
      logic [FLOOR_W-1:0]  reached;
      logic [FLOOR_W-1:0]  goal;
      bit                  doors_open;
      bit                  opening;
      bit                  closing;
      bit                  extended;
      logic [TICKS_W-1:0]  elapsed;
      logic [DOOR_W-1:0]   door_pos;
      logic [LAMP_W-1:0]   lamps;
      logic [FLOOR_W-1:0]  waiting_floors[$];

      rsp_type             expected_views[$];
      int unsigned         failures;

      function new();
         pitch      = PITCH_RESET;
         travel     = TRAVEL_STEP_RESET;
         open_limit = OPEN_TICKS_RESET;
         door_rate  = DOOR_STEP_RESET;
         door_full  = DOOR_TRAVEL_RESET;
         mode       = MODE_IDLE;
         height     = '0;
         reached    = GROUND_FLOOR;
         goal       = GROUND_FLOOR;
         doors_open = 1'b0;
         opening    = 1'b0;
         closing    = 1'b0;
         extended   = 1'b0;
         elapsed    = '0;
         door_pos   = '0;
         lamps      = '0;
         failures   = 0;
      endfunction

      function void apply_setting(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FLOOR_PITCH: pitch      = data[PITCH_W-1:0];
            CSR_TRAVEL_STEP: travel     = data[STEP_W-1:0];
            CSR_OPEN_TICKS:  open_limit = data[TICKS_W-1:0];
            CSR_DOOR_STEP:   door_rate  = data[DOOR_W-1:0];
            CSR_DOOR_TRAVEL: door_full  = data[DOOR_W-1:0];
            default: ;
         endcase
      endfunction

      function bit at_rest();
         return mode == MODE_IDLE && waiting_floors.size() == 0;
      endfunction

      function int pending();
         return expected_views.size();
      endfunction

      function void open_car_doors();
         doors_open = 1'b1;
         mode       = MODE_OPEN;
         elapsed    = '0;
         opening    = 1'b1;
         closing    = 1'b0;
         extended   = 1'b0;
      endfunction

      // timeout, dequeue, travel step, door animation, in that order
      function void advance_tick();
         int goal_y;
         int y;
         int next_pos;
         bit arrived;
         if (elapsed != '1) elapsed++;
         if (mode == MODE_OPEN && elapsed >= open_limit) begin
            doors_open = 1'b0;
            mode       = MODE_IDLE;
            opening    = 1'b0;
            closing    = 1'b1;
         end
         if (mode == MODE_IDLE && waiting_floors.size() != 0) begin
            goal = waiting_floors.pop_front();
            mode = MODE_MOVING;
         end
         if (mode == MODE_MOVING) begin
            goal_y = int'(goal) * int'(pitch);
            y      = int'(height);
            if (goal_y > y) begin
               y += int'(travel);
               arrived = y >= goal_y;
            end else begin
               y -= int'(travel);
               arrived = y <= goal_y;
            end
            if (arrived) begin
               height  = HEIGHT_W'(goal_y);
               reached = goal;
               open_car_doors();
               lamps[reached] = 1'b0;
            end else begin
               height = HEIGHT_W'(y);
            end
         end
         if (opening) begin
            next_pos = int'(door_pos) + int'(door_rate);
            if (next_pos >= int'(door_full)) begin
               door_pos = door_full;
               opening  = 1'b0;
            end else begin
               door_pos = DOOR_W'(next_pos);
            end
         end
         if (closing) begin
            if (door_pos <= door_rate) begin
               door_pos = '0;
               closing  = 1'b0;
               extended = 1'b0;
            end else begin
               door_pos -= door_rate;
            end
         end
      endfunction

      function void record_command(logic [CMD_W-1:0] cmd, logic [FLOOR_W-1:0] fl,
                                   logic want_lamp);
         logic [FLOOR_W-1:0] dest;
         bit                 dropped;
         rsp_type            view;
         dropped = 1'b0;
         case (cmd)
            CMD_TICK: advance_tick();
            CMD_REQUEST: begin
               dest = (fl > FLOOR_COUNT - 1) ? FLOOR_W'(FLOOR_COUNT - 1) : fl;
               if (waiting_floors.size() >= QUEUE_DEPTH) begin
                  dropped = 1'b1;
               end else begin
                  waiting_floors.push_back(dest);
                  if (want_lamp && dest < LAMP_W) lamps[dest] = 1'b1;
               end
            end
            CMD_OPEN: begin
               if (!doors_open && mode == MODE_IDLE) begin
                  open_car_doors();
               end else if (doors_open && !extended) begin
                  elapsed  = '0;
                  extended = 1'b1;
               end
            end
            CMD_CLOSE: begin
               if (doors_open) begin
                  closing    = 1'b1;
                  opening    = 1'b0;
                  doors_open = 1'b0;
                  elapsed    = open_limit;
                  extended   = 1'b0;
               end
            end
            CMD_STOP: mode = MODE_STOPPED;
            default: ;
         endcase
         view.car_position    = height;
         view.current_floor   = reached;
         view.target_floor    = goal;
         view.mode            = mode;
         view.doors_open_flag = doors_open;
         view.door_offset     = door_pos;
         view.lamp_bits       = lamps;
         view.request_dropped = dropped;
         view.queue_count     = QCNT_W'(waiting_floors.size());
         expected_views.push_back(view);
      endfunction

      function void check_field(string name, logic [CSR_DATA_W-1:0] want,
                                logic [CSR_DATA_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void compare_view(rsp_type got);
         rsp_type want;
         if (expected_views.size() == 0) begin
            $error("result transaction with no command waiting for it");
            failures++;
            return;
         end
         want = expected_views.pop_front();
         check_field("car_position", want.car_position, got.car_position);
         check_field("current_floor", want.current_floor, got.current_floor);
         check_field("target_floor", want.target_floor, got.target_floor);
         check_field("mode", want.mode, got.mode);
         check_field("doors_open_flag", want.doors_open_flag, got.doors_open_flag);
         check_field("door_offset", want.door_offset, got.door_offset);
         check_field("lamp_bits", want.lamp_bits, got.lamp_bits);
         check_field("request_dropped", want.request_dropped, got.request_dropped);
         check_field("queue_count", want.queue_count, got.queue_count);
      endfunction
   endclass

endpackage

// File: tb/elevator_car_controller_top_test.sv
// elevator_car_controller_top_test: self-checking bench for the elevator car controller
// drives commands and settings, checks every result against ecc_car_tracker_pkg
// depends on ecc_pkg, ecc_car_tracker_pkg and elevator_car_controller_top
`timescale 1ns / 1ps

module elevator_car_controller_top_test;
   import ecc_pkg::*;
   import ecc_car_tracker_pkg::*;

   localparam int HALF_HIGH       = 6;
   localparam int HALF_LOW        = 6;
   localparam int HOLD_OFF_CYCLES = 64;
   // results pass the input and result registers after acceptance; SETTLE_CYCLES spare edges catch any stray one
   localparam int SETTLE_CYCLES   = 6;
   // ticks around the forced close with the longest open time
   localparam int SOAK_TICKS      = 12;
   // limit on the whole run, in ns
   localparam longint RUN_LIMIT_NS = 2_000_000;

   typedef enum int {SEQ_TRIP, SEQ_FLOOD, SEQ_DOORS, SEQ_NOISE, SEQ_TICKS} burst_kind;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_command    = '0;
   logic [FLOOR_W-1:0]    req_floor      = '0;
   logic                  req_light_lamp = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [HEIGHT_W-1:0]   rsp_car_position;
   logic [FLOOR_W-1:0]    rsp_current_floor;
   logic [FLOOR_W-1:0]    rsp_target_floor;
   logic [1:0]            rsp_mode;
   logic                  rsp_doors_open_flag;
   logic [DOOR_W-1:0]     rsp_door_offset;
   logic [LAMP_W-1:0]     rsp_lamp_bits;
   logic                  rsp_request_dropped;
   logic [QCNT_W-1:0]     rsp_queue_count;
   logic                  csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   car_tracker  shadow_car;
   // quiet_tail and hold_asks are shared between the two sides; the rest is sender-only
   bit          quiet_tail    = 1'b0;
   int          hold_asks     = 0;
   int          send_run_left = 0;
   int unsigned items_sent    = 0;

   always begin
      #(HALF_LOW) clock = 1'b1;
      #(HALF_HIGH) clock = 1'b0;
   end

   elevator_car_controller_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_floor           (req_floor),
      .req_light_lamp      (req_light_lamp),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_car_position    (rsp_car_position),
      .rsp_current_floor   (rsp_current_floor),
      .rsp_target_floor    (rsp_target_floor),
      .rsp_mode            (rsp_mode),
      .rsp_doors_open_flag (rsp_doors_open_flag),
      .rsp_door_offset     (rsp_door_offset),
      .rsp_lamp_bits       (rsp_lamp_bits),
      .rsp_request_dropped (rsp_request_dropped),
      .rsp_queue_count     (rsp_queue_count),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // ---------------------------------------------------------------- sender side

   // one command transaction; a random gap may come before it
   task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [FLOOR_W-1:0] fl,
                                input logic lamp);
      if (!quiet_tail) begin
         if (send_run_left > 0) begin
            send_run_left--;
         end else if ($urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            // now and then a long stretch with no gaps at all
            send_run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(0, 6);
         end
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_floor      <= fl;
      req_light_lamp <= lamp;
      // sampled before the edge updates anything, so no race with the block
      do @(posedge clock); while (req_stall !== 1'b0);
      shadow_car.record_command(cmd, fl, lamp);
      items_sent++;
   endtask

   function automatic logic [FLOOR_W-1:0] any_floor();
      return FLOOR_W'($urandom);
   endfunction

   function automatic logic any_bit();
      return 1'($urandom);
   endfunction

   // every code except stop, so the car stays usable
   function automatic logic [CMD_W-1:0] any_live_command();
      logic [CMD_W-1:0] code;
      code = CMD_W'($urandom_range(0, CMD_SPARE_LAST - 1));
      if (code >= CMD_STOP) code++;
      return code;
   endfunction

   // stop sending until every result is back, then let the pipe empty
   task automatic drain_results();
      req_valid <= 1'b0;
      while (shadow_car.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all five registers, back to back, only with nothing in flight
   task automatic load_settings(input int unsigned pitch, input int unsigned step,
                                input int unsigned ticks, input int unsigned dstep,
                                input int unsigned dtravel);
      csr_index_type         regs[5];
      int                    widths[5];
      int unsigned           values[5];
      logic [CSR_DATA_W-1:0] word;
      regs   = '{CSR_FLOOR_PITCH, CSR_TRAVEL_STEP, CSR_OPEN_TICKS, CSR_DOOR_STEP,
                 CSR_DOOR_TRAVEL};
      widths = '{PITCH_W, STEP_W, TICKS_W, DOOR_W, DOOR_W};
      values = '{pitch, step, ticks, dstep, dtravel};
      drain_results();
      foreach (regs[i]) begin
         // bits above the register width carry junk that must be dropped
         word = CSR_DATA_W'(values[i]) | CSR_DATA_W'($urandom << widths[i]);
         csr_write_en   <= 1'b1;
         csr_index      <= regs[i];
         csr_write_data <= word;
         @(posedge clock);
         shadow_car.apply_setting(regs[i], word);
      end
      csr_write_en <= 1'b0;
   endtask

   function automatic burst_kind pick_burst();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return SEQ_TRIP;
      if (r == 4) return SEQ_FLOOD;
      if (r == 5) return SEQ_DOORS;
      if (r == 6) return SEQ_NOISE;
      return SEQ_TICKS;
   endfunction

   // short command sequences that actually make the car travel and the doors cycle
   task automatic emit_burst(input burst_kind kind);
      case (kind)
         SEQ_TRIP: begin
            repeat ($urandom_range(1, 3)) offer_command(CMD_REQUEST, any_floor(), any_bit());
            repeat ($urandom_range(1, 24)) offer_command(CMD_TICK, any_floor(), any_bit());
         end
         SEQ_FLOOD: begin
            // QUEUE_DEPTH - 2 to QUEUE_DEPTH + 4 requests, enough to overflow the queue at the top of the range
            repeat ($urandom_range(QUEUE_DEPTH - 2, QUEUE_DEPTH + 4)) begin
               offer_command(CMD_REQUEST, any_floor(), any_bit());
            end
            repeat ($urandom_range(1, 8)) offer_command(CMD_TICK, any_floor(), any_bit());
         end
         SEQ_DOORS: begin
            repeat ($urandom_range(2, 6)) begin
               case ($urandom_range(0, 2))
                  0:       offer_command(CMD_OPEN, any_floor(), any_bit());
                  1:       offer_command(CMD_CLOSE, any_floor(), any_bit());
                  default: offer_command(CMD_TICK, any_floor(), any_bit());
               endcase
            end
         end
         SEQ_NOISE: begin
            repeat ($urandom_range(1, 3)) offer_command(any_live_command(), any_floor(), any_bit());
         end
         default: begin
            repeat ($urandom_range(1, 12)) offer_command(CMD_TICK, any_floor(), any_bit());
         end
      endcase
   endtask

   task automatic run_phase(input int unsigned count);
      int unsigned first;
      first = items_sent;
      while (items_sent - first < count) emit_burst(pick_burst());
   endtask

   // tick until the car is idle with an empty queue
   task automatic settle_car();
      while (!shadow_car.at_rest()) offer_command(CMD_TICK, any_floor(), any_bit());
   endtask

   initial begin : command_side
      shadow_car = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset settings
      offer_command(CMD_OPEN, '0, 1'b0);             // idle car with shut doors opens
      offer_command(CMD_OPEN, '0, 1'b0);             // open time restarted once
      offer_command(CMD_OPEN, '0, 1'b0);             // second extension ignored
      offer_command(CMD_CLOSE, '0, 1'b0);            // forces the timeout
      offer_command(CMD_TICK, '0, 1'b0);             // doors shut, car idle again
      offer_command(CMD_CLOSE, '1, 1'b1);            // doors already shut, ignored
      offer_command(CMD_REQUEST, '0, 1'b1);          // floor the car already sits at
      offer_command(CMD_TICK, '0, 1'b0);             // arrives on this tick, lamp goes dark
      offer_command(CMD_OPEN, '0, 1'b0);             // extend while open
      offer_command(CMD_CLOSE, '0, 1'b0);
      offer_command(CMD_REQUEST, '1, 1'b1);          // top floor with lamp
      offer_command(CMD_REQUEST, FLOOR_W'(6), 1'b0); // no lamp
      offer_command(CMD_SPARE_FIRST, '1, 1'b1);      // unused codes change nothing
      offer_command(CMD_SPARE_FIRST + 1'b1, '0, 1'b0);
      offer_command(CMD_SPARE_LAST, '1, 1'b1);
      offer_command(CMD_TICK, '1, 1'b1);             // timeout, dequeue and first step together
      offer_command(CMD_OPEN, '0, 1'b0);             // ignored while moving
      offer_command(CMD_CLOSE, '0, 1'b0);
      repeat (4) offer_command(CMD_TICK, '0, 1'b0);

      // short floors and doors so trips complete quickly
      load_settings(8, 3, 5, 3, 10);
      emit_burst(SEQ_FLOOD);
      run_phase(40);
      // receiver holds off while this side keeps offering with no gaps
      hold_asks++;
      send_run_left = HOLD_OFF_CYCLES;
      run_phase(80);

      // largest pitch, step and door values: one tick per floor, doors snap open
      load_settings(4095, 4095, 1, 1023, 1023);
      run_phase(100);

      // smallest values
      load_settings(1, 1, 1, 1, 1);
      run_phase(100);

      // tiny pitch with a huge step, overshoot every time
      load_settings(1, 4095, 2, 1023, 1);
      run_phase(60);

      repeat (3) begin
         load_settings($urandom_range(1, 40), $urandom_range(1, 16), $urandom_range(1, 20),
                       $urandom_range(1, 12), $urandom_range(1, 40));
         run_phase(60);
      end

      // empty the queue fast: every trip lands in one tick, doors time out at once
      load_settings(1, 4095, 1, 1023, 64);
      settle_car();
      // longest open time: close forces the count to its ceiling, next tick shuts
      load_settings(16, 4, 65535, 1, 64);
      offer_command(CMD_OPEN, '0, 1'b0);
      repeat (SOAK_TICKS) offer_command(CMD_TICK, any_floor(), any_bit());
      offer_command(CMD_CLOSE, '0, 1'b0);
      repeat (SOAK_TICKS) offer_command(CMD_TICK, any_floor(), any_bit());

      // tail with no idling on either side; stop keeps the car in the stopped mode for good
      quiet_tail = 1'b1;
      load_settings($urandom_range(1, 40), $urandom_range(1, 16), $urandom_range(1, 20),
                    $urandom_range(1, 12), $urandom_range(1, 40));
      offer_command(CMD_REQUEST, FLOOR_W'(5), 1'b1);
      offer_command(CMD_REQUEST, FLOOR_W'(2), 1'b1);
      offer_command(CMD_TICK, '0, 1'b0);
      offer_command(CMD_STOP, any_floor(), any_bit());
      repeat (40) begin
         offer_command(CMD_W'($urandom_range(0, CMD_SPARE_LAST)), any_floor(), any_bit());
      end

      drain_results();
      if (shadow_car.failures == 0) begin
         $display("elevator_car_controller_top_test: done, clean");
      end else begin
         $display("elevator_car_controller_top_test: done, errors");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver side

   // checks each accepted result transaction and drives the stall in bursts
   initial begin : result_side
      int      stall_left;
      int      run_left;
      int      hold_served;
      rsp_type got;
      stall_left  = 0;
      run_left    = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.car_position    = rsp_car_position;
            got.current_floor   = rsp_current_floor;
            got.target_floor    = rsp_target_floor;
            got.mode            = mode_type'(rsp_mode);
            got.doors_open_flag = rsp_doors_open_flag;
            got.door_offset     = rsp_door_offset;
            got.lamp_bits       = rsp_lamp_bits;
            got.request_dropped = rsp_request_dropped;
            got.queue_count     = rsp_queue_count;
            shadow_car.compare_view(got);
         end
         // long hold-off, counted here, so the block backs up into req_stall
         if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            stall_left  = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (quiet_tail || run_left > 0) begin
            rsp_stall <= 1'b0;
            if (run_left > 0) run_left--;
         end else if ($urandom_range(0, 2) == 0) begin
            // stalled burst: this cycle plus stall_left more
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 7);
         end else begin
            rsp_stall <= 1'b0;
            run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
         end
      end
   end

   // hard stop if the block hangs
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("elevator_car_controller_top_test: done, errors");
      $finish;
   end

endmodule
